@@ src/wwci_pkg.sv @@
// shared types, constants and register codes of the window charge integrator
`timescale 1ns / 1ps

package wwci_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned CELL_W     = 11;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned OFFSET_W   = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // count word is taken modulo the cell depth
  localparam int unsigned MAX_CELLS  = 1024;
  localparam int unsigned COUNT_W    = $clog2(MAX_CELLS);

  localparam logic [WORD_W-1:0] HEADER_WORD = 32'hffff_dddd;
  localparam int unsigned SKIP_WORDS = 8;
  localparam int unsigned POS_W      = 4;

  localparam int unsigned DEF_CHANNELS    = 2;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [CELL_W-1:0]          RST_WINDOW_AFTER  = 11'd400;
  localparam logic [CELL_W-1:0]          RST_WINDOW_BEFORE = 11'd500;
  localparam logic [ADC_W-1:0]           RST_PEDESTAL      = 12'd1700;
  localparam logic [SHIFT_W-1:0]         RST_SUM_SHIFT     = 4'd4;
  localparam logic signed [OFFSET_W-1:0] RST_RESULT_OFFSET = -13'sd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_AFTER  = 3'd0,
    REG_WINDOW_BEFORE = 3'd1,
    REG_PEDESTAL      = 3'd2,
    REG_SUM_SHIFT     = 3'd3,
    REG_RESULT_OFFSET = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CELL_W-1:0] after;
    logic [CELL_W-1:0] upper;
  } window_cfg_t;

  typedef struct packed {
    logic [ADC_W-1:0]           pedestal;
    logic [SHIFT_W-1:0]         shift;
    logic signed [OFFSET_W-1:0] offset;
  } calc_cfg_t;

  // one classified sample handed from front to back
  typedef struct packed {
    logic             chan;
    logic             last;
    logic             in_win;
    logic [ADC_W-1:0] adc;
  } sample_t;

endpackage

@@ src/wwci_fifo.sv @@
// small flop-based queue between the word parser and the accumulator
`timescale 1ns / 1ps

module wwci_fifo #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ src/wwci_front.sv @@
// word parser: finds headers, skips, reads the count and tags samples
`timescale 1ns / 1ps

module wwci_front #(
  parameter int unsigned CHANNELS = wwci_pkg::DEF_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wwci_pkg::WORD_W-1:0]  in_word,
  input  wwci_pkg::window_cfg_t        win,
  output logic                         push_valid,
  input  logic                         push_ready,
  output wwci_pkg::sample_t            push_data
);

  import wwci_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_SKIP,
    ST_COUNT,
    ST_DATA
  } state_t;

  state_t            state;
  logic [POS_W-1:0]  hdr_pos;
  logic [CELL_W-1:0] samples;
  logic [CELL_W-1:0] cell_idx;
  logic [CH_W-1:0]   chan;

  logic              accept;
  logic              in_win;
  logic [CELL_W-1:0] cell_inc;
  logic              last;
  logic              chan_last;

  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign in_win    = (cell_idx > win.after) && (cell_idx < win.upper);
  assign cell_inc  = cell_idx + CELL_W'(1);
  assign last      = (cell_inc == samples);
  assign chan_last = (chan == CH_W'(CHANNELS - 1));

  assign push_valid       = accept && (state == ST_DATA);
  assign push_data.chan   = chan[0];
  assign push_data.last   = last;
  assign push_data.in_win = in_win;
  assign push_data.adc    = in_word[ADC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_WAIT;
      hdr_pos  <= '0;
      samples  <= '0;
      cell_idx <= '0;
      chan     <= '0;
    end else if (accept) begin
      unique case (state)
        ST_WAIT: begin
          if (in_word == HEADER_WORD) begin
            state   <= ST_SKIP;
            hdr_pos <= '0;
          end
        end
        ST_SKIP: begin
          hdr_pos <= hdr_pos + POS_W'(1);
          if (hdr_pos == POS_W'(SKIP_WORDS - 1)) begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          samples  <= CELL_W'(in_word[COUNT_W-1:0]) + CELL_W'(1);
          cell_idx <= '0;
          chan     <= '0;
          state    <= ST_DATA;
        end
        ST_DATA: begin
          if (last) begin
            cell_idx <= '0;
            if (chan_last) begin
              chan  <= '0;
              state <= ST_WAIT;
            end else begin
              chan <= chan + CH_W'(1);
            end
          end else begin
            cell_idx <= cell_inc;
          end
        end
        default: state <= ST_WAIT;
      endcase
    end
  end

endmodule

@@ src/wwci_back.sv @@
// accumulator and result stage: sums window samples, scales and offsets
`timescale 1ns / 1ps

module wwci_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  wwci_pkg::sample_t                 pop_data,
  input  wwci_pkg::calc_cfg_t               calc,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_chan,
  output logic signed [wwci_pkg::SUM_W-1:0] out_charge
);

  import wwci_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [ADC_W:0]   diff;

  // finished sum waiting for scaling
  logic                    fin_valid;
  logic                    fin_chan;
  logic signed [SUM_W-1:0] fin_sum;
  logic signed [SUM_W-1:0] shifted;
  logic signed [SUM_W-1:0] charge_next;

  logic fin_move;
  logic pop;

  assign fin_move  = fin_valid && (!out_valid || out_ready);
  assign pop_ready = !fin_valid || fin_move;
  assign pop       = pop_valid && pop_ready;

  assign diff     = $signed({1'b0, pop_data.adc}) - $signed({1'b0, calc.pedestal});
  assign sum_next = pop_data.in_win
                    ? sum + {{(SUM_W-ADC_W-1){diff[ADC_W]}}, diff}
                    : sum;

  assign shifted     = fin_sum >>> calc.shift;
  assign charge_next = shifted + {{(SUM_W-OFFSET_W){calc.offset[OFFSET_W-1]}}, calc.offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_move) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && pop_data.last) begin
        fin_valid <= 1'b1;
      end else if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (pop) begin
        if (pop_data.last) begin
          sum <= '0;
        end else begin
          sum <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.last) begin
      fin_sum  <= sum_next;
      fin_chan <= pop_data.chan;
    end
    if (fin_move) begin
      out_chan   <= fin_chan;
      out_charge <= charge_next;
    end
  end

endmodule

@@ src/waveform_window_charge_integrator.sv @@
// top level of the waveform window charge integrator
`timescale 1ns / 1ps

// Takes one 32-bit digitizer word per beat. Outside an event only the header
// word 0xffffdddd matters; after it eight words are skipped, and the next word
// gives the sample count per channel (low 10 bits plus one). Then that many
// samples follow for each of CHANNELS_PER_EVENT channels; a header value inside
// the samples is just a sample. Samples whose cell index lies strictly between
// window_after and window_before add (adc - pedestal) to the channel sum, and
// at the end of each channel one result beat leaves with
// (sum >>> sum_shift) + result_offset and the channel number (its low bit).
// Rate: one input word per cycle, sustained. The parser in front tags each
// sample and drops it into a QUEUE_DEPTH-entry queue; the accumulator behind it
// drains one entry per cycle, so input stalls only once downstream backpressure
// has filled the result stage and the queue. With nothing ahead, m_tvalid
// rises once the channel's last sample has passed the queue, fin_sum and the
// output register. The user writes configuration via cfg_we/cfg_index/
// cfg_data only while no event is in flight; the block does not enforce it.
module waveform_window_charge_integrator #(
  parameter int unsigned CHANNELS_PER_EVENT = wwci_pkg::DEF_CHANNELS,
  parameter int unsigned QUEUE_DEPTH        = wwci_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // [31:0] stream_word
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [23:0] charge
  output logic                            m_tuser,   // [0] channel_index
  // register writes
  input  logic                            cfg_we,
  input  logic [wwci_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wwci_pkg::CFG_DATA_W-1:0] cfg_data
);

  import wwci_pkg::*;

  localparam int unsigned ENTRY_W = $bits(sample_t);

  // configuration registers
  window_cfg_t win;
  calc_cfg_t   calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.after     <= RST_WINDOW_AFTER;
      win.upper     <= RST_WINDOW_BEFORE;
      calc.pedestal <= RST_PEDESTAL;
      calc.shift    <= RST_SUM_SHIFT;
      calc.offset   <= RST_RESULT_OFFSET;
    end else if (cfg_we) begin
      // indexes beyond the list are ignored
      case (cfg_index)
        REG_WINDOW_AFTER:  win.after     <= cfg_data[CELL_W-1:0];
        REG_WINDOW_BEFORE: win.upper     <= cfg_data[CELL_W-1:0];
        REG_PEDESTAL:      calc.pedestal <= cfg_data[ADC_W-1:0];
        REG_SUM_SHIFT:     calc.shift    <= cfg_data[SHIFT_W-1:0];
        REG_RESULT_OFFSET: calc.offset   <= $signed(cfg_data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  // front: parse the word stream into tagged samples
  logic             push_valid;
  logic             push_ready;
  sample_t          push_data;

  wwci_front #(
    .CHANNELS (CHANNELS_PER_EVENT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_word    (s_tdata),
    .win        (win),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue between parser and accumulator
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_bits;
  sample_t            pop_data;

  wwci_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (ENTRY_W'(push_data)),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_bits)
  );

  assign pop_data = sample_t'(pop_bits);

  // back: accumulate, scale, offset, hold result for the output beat
  logic signed [SUM_W-1:0] charge;

  wwci_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .calc       (calc),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_chan   (m_tuser),
    .out_charge (charge)
  );

  assign m_tdata = charge;

endmodule
